// ----- rtl/core/frame_time_window_stats_macros.svh -----
// assertion macros for the frame time window statistics block
`ifndef FRAME_TIME_WINDOW_STATS_MACROS_SVH
`define FRAME_TIME_WINDOW_STATS_MACROS_SVH
`ifndef SYNTHESIS
`define FTWS_ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTWS_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define FTWS_ASSERT_PROP(label, prop, msg)
`define FTWS_ASSERT_HOLDS(label, expr, msg)
`endif
`endif

// ----- rtl/core/ftws_pkg.sv -----
package ftws_pkg;

    localparam int TIME_BITS    = 20;
    localparam int FILL_BITS    = 7;
    localparam int CLASS_BITS   = 2;
    localparam int LIMIT_BITS   = 20;
    localparam int CFG_IDX_BITS = 2;

    localparam int DEF_WINDOW      = 120;
    localparam int DEF_SAMPLE_BITS = 20;

    localparam logic [LIMIT_BITS-1:0] BUDGET_RESET  = LIMIT_BITS'(4265);
    localparam logic [LIMIT_BITS-1:0] WARNING_RESET = LIMIT_BITS'(3584);

    localparam logic [CFG_IDX_BITS-1:0] CFG_BUDGET  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WARNING = CFG_IDX_BITS'(1);

    // floor(fill / 20) as (fill * 3277) >> 16, exact for fill up to 1024
    localparam int P95_MUL      = 3277;
    localparam int P95_MUL_BITS = 12;
    localparam int P95_SHIFT    = 16;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_OK   = 2'd0,
        CLASS_WARN = 2'd1,
        CLASS_OVER = 2'd2
    } class_t;

endpackage

// ----- rtl/core/frame_time_window_stats.sv -----
// per request, the sorted store is searched for one copy of the oldest sample (once the window
// is full) and the new sample is placed by an insertion shift; a radix-2 divider then forms the
// average from SAMPLE_BITS + clog2(WINDOW + 1) quotient bits
// a new request is taken while the last result waits, and the next finished result then waits
// until the last one is taken
// reset (async, active low) empties the window and restores both limits, memories kept
`include "frame_time_window_stats_macros.svh"

module frame_time_window_stats #(
    parameter int WINDOW      = ftws_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = ftws_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [SAMPLE_BITS-1:0]             frame_time,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ftws_pkg::TIME_BITS-1:0]     current_time,
    output logic [ftws_pkg::TIME_BITS-1:0]     average_time,
    output logic [ftws_pkg::TIME_BITS-1:0]     max_time,
    output logic [ftws_pkg::TIME_BITS-1:0]     p95_time,
    output logic [ftws_pkg::FILL_BITS-1:0]     window_fill,
    output logic [ftws_pkg::CLASS_BITS-1:0]    current_class,
    output logic [ftws_pkg::CLASS_BITS-1:0]    p95_class,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ftws_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ftws_pkg::LIMIT_BITS-1:0]    cfg_data
);

    import ftws_pkg::*;

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int BIT_W  = $clog2(SUM_W + 1);
    localparam int CMP_W  = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
    localparam int PROD_W = CNT_W + P95_MUL_BITS;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [BIT_W-1:0]       bit_t;
    typedef logic [CMP_W-1:0]       cmp_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [TIME_BITS-1:0]   time_t;
    typedef logic [LIMIT_BITS-1:0]  limit_t;

    localparam idx_t LAST_IDX = idx_t'(WINDOW - 1);
    localparam cnt_t FULL_CNT = cnt_t'(WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BS_ADDR,
        ST_BS_CMP,
        ST_SH_START,
        ST_SH,
        ST_PUT,
        ST_MAX_RD,
        ST_P95_RD,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t  state_reg;
    idx_t    wr_pos_reg;
    cnt_t    count_reg;
    sum_t    sum_reg;
    limit_t  budget_reg;
    limit_t  warning_reg;
    sample_t v_reg;
    sample_t old_reg;
    idx_t    lo_reg;
    idx_t    hi_reg;
    idx_t    hole_reg;
    logic    left_reg;
    idx_t    j_reg;
    idx_t    put_reg;
    prod_t   prod_reg;
    sample_t max_reg;
    sample_t p95_reg;
    sum_t    div_q_reg;
    cnt_t    div_rem_reg;
    bit_t    div_bits_reg;

    logic    out_valid_reg;
    time_t   out_cur_reg;
    time_t   out_avg_reg;
    time_t   out_max_reg;
    time_t   out_p95_reg;
    cnt_t    out_fill_reg;
    class_t  out_cur_class_reg;
    class_t  out_p95_class_reg;

    sample_t ring_mem [WINDOW];
    sample_t ring_rdata_reg;
    sample_t sort_mem [WINDOW];
    sample_t sort_rdata_reg;

    logic    in_accept;
    logic    full;
    logic [IDX_W:0] bs_sum;
    idx_t    bs_mid;
    logic    sh_move;
    logic    sh_bound;
    idx_t    sh_dest;
    idx_t    sh_step;
    idx_t    start_j;
    logic    start_bound;
    cnt_t    p95_drop;
    idx_t    p95_idx;
    idx_t    max_idx;
    logic [CNT_W:0] div_shift;
    logic    div_ge;
    cnt_t    div_rem_next;

    logic    sort_we;
    idx_t    sort_waddr;
    sample_t sort_wdata;
    idx_t    sort_raddr;

    function automatic class_t classify(input cmp_t val);
        class_t cls;
        if (val > cmp_t'(budget_reg))
        begin
            cls = CLASS_OVER;
        end
        else if (val >= cmp_t'(warning_reg))
        begin
            cls = CLASS_WARN;
        end
        else
        begin
            cls = CLASS_OK;
        end
        return cls;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign full      = (count_reg == FULL_CNT);

    assign bs_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign bs_mid = bs_sum[IDX_W:1];

    // insertion shift: left moves larger entries up, right moves smaller entries down
    assign sh_move     = left_reg ? (sort_rdata_reg > v_reg) : (sort_rdata_reg < v_reg);
    assign sh_bound    = left_reg ? (j_reg == '0) : (j_reg == LAST_IDX);
    assign sh_dest     = left_reg ? (j_reg + idx_t'(1)) : (j_reg - idx_t'(1));
    assign sh_step     = left_reg ? (j_reg - idx_t'(1)) : (j_reg + idx_t'(1));
    assign start_j     = left_reg ? (hole_reg - idx_t'(1)) : (hole_reg + idx_t'(1));
    assign start_bound = left_reg ? (hole_reg == '0) : (hole_reg == LAST_IDX);

    // ceil(19 * fill / 20) - 1 = fill - floor(fill / 20) - 1
    assign p95_drop = cnt_t'(prod_reg >> P95_SHIFT);
    assign p95_idx  = idx_t'(count_reg - p95_drop - cnt_t'(1));
    assign max_idx  = idx_t'(count_reg - cnt_t'(1));

    assign div_shift    = {div_rem_reg, div_q_reg[SUM_W-1]};
    assign div_ge       = (div_shift >= {1'b0, count_reg});
    assign div_rem_next = div_ge ? cnt_t'(div_shift - {1'b0, count_reg}) : cnt_t'(div_shift);

    always_comb
    begin
        sort_we    = 1'b0;
        sort_waddr = '0;
        sort_wdata = v_reg;
        sort_raddr = '0;
        case (state_reg)
            ST_BS_ADDR:
            begin
                sort_raddr = bs_mid;
            end
            ST_SH_START:
            begin
                sort_raddr = start_j;
            end
            ST_SH:
            begin
                sort_raddr = sh_step;
                if (sh_move)
                begin
                    sort_we    = 1'b1;
                    sort_waddr = sh_dest;
                    sort_wdata = sort_rdata_reg;
                end
            end
            ST_PUT:
            begin
                sort_we    = 1'b1;
                sort_waddr = put_reg;
            end
            ST_MAX_RD:
            begin
                sort_raddr = max_idx;
            end
            ST_P95_RD:
            begin
                sort_raddr = p95_idx;
            end
            default:
            begin
                sort_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ring_mem[wr_pos_reg] <= frame_time;
        end
        ring_rdata_reg <= ring_mem[wr_pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rdata_reg <= sort_mem[sort_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_pos_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            budget_reg    <= BUDGET_RESET;
            warning_reg   <= WARNING_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BUDGET:  budget_reg  <= cfg_data;
                    CFG_WARNING: warning_reg <= cfg_data;
                    default:     ;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        v_reg      <= frame_time;
                        wr_pos_reg <= (wr_pos_reg == LAST_IDX) ? '0 : wr_pos_reg + idx_t'(1);
                        state_reg  <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (full)
                    begin
                        // drop the oldest sample: find one copy of it in the sorted store
                        old_reg   <= ring_rdata_reg;
                        sum_reg   <= sum_reg - sum_t'(ring_rdata_reg);
                        lo_reg    <= '0;
                        hi_reg    <= LAST_IDX;
                        state_reg <= ST_BS_ADDR;
                    end
                    else
                    begin
                        hole_reg  <= idx_t'(count_reg);
                        left_reg  <= 1'b1;
                        state_reg <= ST_SH_START;
                    end
                end
                ST_BS_ADDR:
                begin
                    if (lo_reg == hi_reg)
                    begin
                        hole_reg  <= lo_reg;
                        left_reg  <= (v_reg < old_reg);
                        state_reg <= ST_SH_START;
                    end
                    else
                    begin
                        state_reg <= ST_BS_CMP;
                    end
                end
                ST_BS_CMP:
                begin
                    if (sort_rdata_reg < old_reg)
                    begin
                        lo_reg <= bs_mid + idx_t'(1);
                    end
                    else
                    begin
                        hi_reg <= bs_mid;
                    end
                    state_reg <= ST_BS_ADDR;
                end
                ST_SH_START:
                begin
                    if (start_bound)
                    begin
                        put_reg   <= hole_reg;
                        state_reg <= ST_PUT;
                    end
                    else
                    begin
                        j_reg     <= start_j;
                        state_reg <= ST_SH;
                    end
                end
                ST_SH:
                begin
                    if (sh_move)
                    begin
                        if (sh_bound)
                        begin
                            put_reg   <= j_reg;
                            state_reg <= ST_PUT;
                        end
                        else
                        begin
                            j_reg <= sh_step;
                        end
                    end
                    else
                    begin
                        put_reg   <= sh_dest;
                        state_reg <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    if (!full)
                    begin
                        count_reg <= count_reg + cnt_t'(1);
                    end
                    sum_reg   <= sum_reg + sum_t'(v_reg);
                    state_reg <= ST_MAX_RD;
                end
                ST_MAX_RD:
                begin
                    prod_reg  <= prod_t'(count_reg) * prod_t'(P95_MUL);
                    state_reg <= ST_P95_RD;
                end
                ST_P95_RD:
                begin
                    max_reg   <= sort_rdata_reg;
                    state_reg <= ST_DIV_INIT;
                end
                ST_DIV_INIT:
                begin
                    p95_reg      <= sort_rdata_reg;
                    div_q_reg    <= sum_reg;
                    div_rem_reg  <= '0;
                    div_bits_reg <= bit_t'(SUM_W);
                    state_reg    <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_q_reg    <= {div_q_reg[SUM_W-2:0], div_ge};
                    div_rem_reg  <= div_rem_next;
                    div_bits_reg <= div_bits_reg - bit_t'(1);
                    if (div_bits_reg == bit_t'(1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_cur_reg       <= time_t'(v_reg);
                        out_avg_reg       <= time_t'(div_q_reg);
                        out_max_reg       <= time_t'(max_reg);
                        out_p95_reg       <= time_t'(p95_reg);
                        out_fill_reg      <= count_reg;
                        out_cur_class_reg <= classify(cmp_t'(v_reg));
                        out_p95_class_reg <= classify(cmp_t'(p95_reg));
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_time  = out_cur_reg;
    assign average_time  = out_avg_reg;
    assign max_time      = out_max_reg;
    assign p95_time      = out_p95_reg;
    assign window_fill   = FILL_BITS'(out_fill_reg);
    assign current_class = out_cur_class_reg;
    assign p95_class     = out_p95_class_reg;

    `FTWS_ASSERT_HOLDS(a_count_bound, count_reg <= FULL_CNT, "window fill beyond window size")
    `FTWS_ASSERT_HOLDS(a_div_rem, state_reg != ST_DIV || div_rem_reg < count_reg, "bad remainder")
    `FTWS_ASSERT_HOLDS(a_max_ge_p95, state_reg != ST_DONE || max_reg >= p95_reg, "p95 above max")
    `FTWS_ASSERT_PROP(a_busy_after_req, in_accept |=> !in_ready, "ready while a request is in work")

endmodule
